[rtl/bgm_pkg.sv]
`default_nettype none

package bgm_pkg;

  typedef enum logic [2:0] {
    ACT_REGISTER = 3'd0,
    ACT_RECORD   = 3'd1,
    ACT_VERIFY   = 3'd2,
    ACT_QUERY    = 3'd3,
    ACT_CLEAR    = 3'd4
  } action_e;

  localparam logic [1:0] VIOL_NONE     = 2'd0;
  localparam logic [1:0] VIOL_UNKNOWN  = 2'd1;
  localparam logic [1:0] VIOL_BYPASSED = 2'd2;

  localparam logic [7:0]  THRESHOLD_RESET = 8'd3;
  localparam logic [7:0]  COUNT_MAX       = 8'hFF;
  localparam logic [63:0] GENERATION_INIT = 64'd1;

  typedef struct packed {
    logic [2:0]  action;
    logic [63:0] guard_id;
    logic [63:0] recorded_generation;
  } in_t;

  typedef struct packed {
    logic [63:0] generation;
    logic [1:0]  violation;
    logic        critical;
    logic        was_bypassed;
    logic        table_full;
  } out_t;

endpackage

`default_nettype wire

[rtl/branch_guard_monitor_table_top.sv]
`default_nettype none

// channel | direction | payload        | handshake
// in      | in        | bgm_pkg::in_t  | in_valid_i / in_stall_o
// out     | out       | bgm_pkg::out_t | out_valid_o / out_stall_i
// cfg     | in        | threshold [7:0]| cfg_we_i, no wait
//
// one transaction per cycle unless the result stalls; input in in_q,
// result in out_q; table update adds no stage: lookup, lowest-free search
// and entry write all happen between the input and result registers
// reset empties the table at once through per-entry valid bits, no sweep
// a stalled result holds the pipeline; the input register still fills once

module branch_guard_monitor_table_top #(
  parameter int unsigned GUARD_ENTRIES = 16
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire bgm_pkg::in_t  in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output bgm_pkg::out_t      out_data_o,
  input  wire logic          cfg_we_i,
  input  wire logic [7:0]    cfg_wdata_i
);

  logic          in_valid_q, in_valid_d;
  bgm_pkg::in_t  in_q;
  logic          out_valid_q, out_valid_d;
  bgm_pkg::out_t out_q, result;
  logic [7:0]    threshold_q;
  logic          proc_en, in_load;

  assign proc_en    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_load    = !in_valid_q || proc_en;
  assign in_stall_o = !in_load;

  always_comb begin
    in_valid_d = in_load ? in_valid_i : in_valid_q;
    if (proc_en) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  bgm_table #(.Entries(GUARD_ENTRIES)) u_table (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .proc_en_i   (proc_en),
    .item_i      (in_q),
    .threshold_i (threshold_q),
    .result_o    (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      threshold_q <= bgm_pkg::THRESHOLD_RESET;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        threshold_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load && in_valid_i) begin
      in_q <= in_data_i;
    end
    if (proc_en) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

[rtl/bgm_lookup.sv]
`default_nettype none

module bgm_lookup #(
  parameter int unsigned Entries = 16
) (
  input  wire logic [Entries-1:0] valid_i,
  input  wire logic [63:0]        keys_i [Entries],
  input  wire logic [63:0]        guard_id_i,
  output logic      [Entries-1:0] match_oh_o,
  output logic      [Entries-1:0] free_oh_o,
  output logic                    hit_o,
  output logic                    any_free_o
);

  logic [Entries-1:0] free;

  always_comb begin
    for (int i = 0; i < Entries; i++) begin
      match_oh_o[i] = valid_i[i] && (keys_i[i] == guard_id_i);
    end
  end

  // lowest free entry isolated by the two's complement trick
  assign free       = ~valid_i;
  assign free_oh_o  = free & (~free + {{(Entries-1){1'b0}}, 1'b1});
  assign hit_o      = |match_oh_o;
  assign any_free_o = |free;

endmodule

`default_nettype wire

[rtl/bgm_table.sv]
`default_nettype none

module bgm_table #(
  parameter int unsigned Entries = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        proc_en_i,
  input  wire bgm_pkg::in_t item_i,
  input  wire logic [7:0]  threshold_i,
  output bgm_pkg::out_t    result_o
);

  logic [Entries-1:0] valid_q;
  logic [Entries-1:0] exec_q;
  logic [7:0]         count_q [Entries];
  logic [63:0]        key_q   [Entries];
  logic [63:0]        gen_q, gen_d;

  logic [Entries-1:0] match_oh, free_oh;
  logic               hit, any_free;

  bgm_lookup #(.Entries(Entries)) u_lookup (
    .valid_i    (valid_q),
    .keys_i     (key_q),
    .guard_id_i (item_i.guard_id),
    .match_oh_o (match_oh),
    .free_oh_o  (free_oh),
    .hit_o      (hit),
    .any_free_o (any_free)
  );

  logic [7:0] sel_count, new_count;
  logic       sel_exec;

  always_comb begin
    sel_count = '0;
    sel_exec  = 1'b0;
    for (int i = 0; i < Entries; i++) begin
      sel_count = sel_count | ({8{match_oh[i]}} & count_q[i]);
      sel_exec  = sel_exec | (match_oh[i] & exec_q[i]);
    end
  end

  // saturating bump, only when the guard never ran since the last verify
  assign new_count = (sel_exec || sel_count == bgm_pkg::COUNT_MAX) ? sel_count
                                                                   : sel_count + 8'd1;

  logic is_reg, is_rec, is_ver, is_clr, stale;
  logic ins_en, rec_hit_en, ver_hit_en, clr_en;

  assign is_reg = item_i.action == bgm_pkg::ACT_REGISTER;
  assign is_rec = item_i.action == bgm_pkg::ACT_RECORD;
  assign is_ver = item_i.action == bgm_pkg::ACT_VERIFY;
  assign is_clr = item_i.action == bgm_pkg::ACT_CLEAR;
  assign stale  = (item_i.recorded_generation != '0) &&
                  (item_i.recorded_generation != gen_q);

  assign ins_en     = proc_en_i && (is_reg || is_rec) && !hit && any_free;
  assign rec_hit_en = proc_en_i && is_rec && hit;
  assign ver_hit_en = proc_en_i && is_ver && !stale && hit;
  assign clr_en     = proc_en_i && is_clr;

  always_comb begin
    gen_d = gen_q;
    if (clr_en) begin
      gen_d = gen_q + 64'd1;
      if (gen_d == '0) begin
        gen_d = bgm_pkg::GENERATION_INIT;
      end
    end
  end

  always_comb begin
    result_o              = '0;
    result_o.generation   = gen_d;
    result_o.violation    = bgm_pkg::VIOL_NONE;
    unique case (item_i.action)
      bgm_pkg::ACT_REGISTER,
      bgm_pkg::ACT_RECORD: begin
        result_o.table_full = !hit && !any_free;
      end
      bgm_pkg::ACT_VERIFY: begin
        if (!stale) begin
          if (!hit) begin
            result_o.violation = bgm_pkg::VIOL_UNKNOWN;
            result_o.critical  = 1'b1;
          end else if (!sel_exec) begin
            result_o.violation = bgm_pkg::VIOL_BYPASSED;
            result_o.critical  = new_count >= threshold_i;
          end
        end
      end
      bgm_pkg::ACT_QUERY: begin
        result_o.was_bypassed = !hit || (sel_count != '0);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      gen_q   <= bgm_pkg::GENERATION_INIT;
    end else begin
      gen_q <= gen_d;
      if (clr_en) begin
        valid_q <= '0;
      end else if (ins_en) begin
        valid_q <= valid_q | free_oh;
      end
    end
  end

  // entry payload: only meaningful while the valid bit is set
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < Entries; i++) begin
      if (ins_en && free_oh[i]) begin
        key_q[i]   <= item_i.guard_id;
        exec_q[i]  <= is_rec;
        count_q[i] <= '0;
      end else if (rec_hit_en && match_oh[i]) begin
        exec_q[i] <= 1'b1;
      end else if (ver_hit_en && match_oh[i]) begin
        exec_q[i]  <= 1'b0;
        count_q[i] <= new_count;
      end
    end
  end

  a_unique_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(match_oh))
    else $error("guard key present in more than one entry");

  a_gen_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gen_q != '0)
    else $error("table generation reached zero");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_en |=> (valid_q == '0) && (gen_q != $past(gen_q)))
    else $error("clear left entries or kept the generation");

  a_full_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc_en_i && result_o.table_full |=> $stable(valid_q))
    else $error("dropped insert changed the table");

endmodule

`default_nettype wire
